@@ rtl/core/clipped_rect_fill_framebuffer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the clipped rectangle fill frame buffer
// Concurrent property wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef CLIPPED_RECT_FILL_FRAMEBUFFER_ASSERT_SVH
`define CLIPPED_RECT_FILL_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication
`define CFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfb assertion failed");

// next-cycle implication
`define CFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfb assertion failed");

`endif

@@ rtl/core/cfb_pkg.sv @@
// ---------------------------------------------------------------------------
// Clipped rectangle fill frame buffer package
// Panel geometry, store sizing, register map and sequencer states.
// ---------------------------------------------------------------------------
package cfb_pkg;

  localparam int LONG_SIDE   = 320;
  localparam int SHORT_SIDE  = 240;
  localparam int MAX_SIDE    = (LONG_SIDE > SHORT_SIDE) ? LONG_SIDE : SHORT_SIDE;
  localparam int STORE_DEPTH = LONG_SIDE * SHORT_SIDE;

  localparam int COORD_W = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int PIX_W   = 16;
  localparam int POS_W   = 16;
  localparam int EXT_W   = POS_W + 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic CFG_IDX_ROTATION = 1'b0;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_FILL,
    S_RDATA
  } cfb_state_e;

endpackage

@@ rtl/core/clipped_rect_fill_framebuffer.sv @@
// Reads: the store word is registered on acceptance and moves to the output
//   register in S_RDATA once that register is free; a fill produces no result.
// Fills: S_SETUP, then S_FILL writes one pixel per cycle (one store write port);
//   an empty fill writes nothing. No new command is taken until back in S_IDLE.
// Reset: control and rotation clear to 0; the pixel store is not cleared and
//   holds undefined words until written.
// ---------------------------------------------------------------------------
// Clipped rectangle fill frame buffer
// Clips signed rectangles to the active area and fills them into a
// single-port-write pixel store; serves single-pixel reads.
// ---------------------------------------------------------------------------
module clipped_rect_fill_framebuffer
  import cfb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [POS_W-1:0]   pos_x_i,
  input  logic [POS_W-1:0]   pos_y_i,
  input  logic [POS_W-1:0]   rect_w_i,
  input  logic [POS_W-1:0]   rect_h_i,
  input  logic [PIX_W-1:0]   fill_color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   pixel_word_o,
  output logic               inside_res_o
);

  cfb_state_e state_q, state_d;

  logic [1:0]         rotation_q;
  logic [COORD_W-1:0] wid, hgt;

  logic [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q, col_q, row_q;
  logic [ADDR_W-1:0]  addr_q, step_q;
  logic [PIX_W-1:0]   color_q;

  logic [PIX_W-1:0]   mem_q [STORE_DEPTH];
  logic [PIX_W-1:0]   rd_data_q;
  logic               rd_inside_q;

  logic               out_valid_q, out_inside_q;
  logic [PIX_W-1:0]   out_word_q;

  logic in_acc, fill_acc, read_acc, out_load, mem_we, col_end, row_end, cfg_wr;

  logic signed [EXT_W-1:0] px_s, py_s, rw_s, rh_s, wid_s, hgt_s;
  logic signed [EXT_W-1:0] x_end, y_end, x_lo, y_lo, x_hi, y_hi;
  logic                    fill_empty, rd_inside;
  logic [2*COORD_W-1:0]    rd_prod, base_prod;
  logic [ADDR_W-1:0]       rd_addr, base_addr;
  logic [COORD_W-1:0]      span;

  assign wid = rotation_q[0] ? COORD_W'(SHORT_SIDE) : COORD_W'(LONG_SIDE);
  assign hgt = rotation_q[0] ? COORD_W'(LONG_SIDE) : COORD_W'(SHORT_SIDE);

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_ROTATION) ? {{(PDATA_W-2){1'b0}}, rotation_q}
                                                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= 2'b0;
    end else if (cfg_wr && paddr[2] == CFG_IDX_ROTATION) begin
      rotation_q <= pwdata[1:0];
    end
  end

  assign px_s  = {pos_x_i[POS_W-1], pos_x_i};
  assign py_s  = {pos_y_i[POS_W-1], pos_y_i};
  assign rw_s  = {rect_w_i[POS_W-1], rect_w_i};
  assign rh_s  = {rect_h_i[POS_W-1], rect_h_i};
  assign wid_s = {{(EXT_W-COORD_W){1'b0}}, wid};
  assign hgt_s = {{(EXT_W-COORD_W){1'b0}}, hgt};

  assign x_end = px_s + rw_s;
  assign y_end = py_s + rh_s;
  assign x_lo  = pos_x_i[POS_W-1] ? '0 : px_s;
  assign y_lo  = pos_y_i[POS_W-1] ? '0 : py_s;
  assign x_hi  = (x_end > wid_s) ? wid_s : x_end;
  assign y_hi  = (y_end > hgt_s) ? hgt_s : y_end;

  assign fill_empty = rect_w_i[POS_W-1] || (rect_w_i == '0) ||
                      rect_h_i[POS_W-1] || (rect_h_i == '0) ||
                      (x_hi <= x_lo) || (y_hi <= y_lo);

  assign rd_inside = !pos_x_i[POS_W-1] && (px_s < wid_s) &&
                     !pos_y_i[POS_W-1] && (py_s < hgt_s);
  assign rd_prod   = pos_y_i[COORD_W-1:0] * wid;
  assign rd_addr   = ADDR_W'(rd_prod) + ADDR_W'(pos_x_i[COORD_W-1:0]);

  assign base_prod = y0_q * wid;
  assign base_addr = ADDR_W'(base_prod) + ADDR_W'(x0_q);
  assign span      = x1_q - x0_q;

  assign col_end = (col_q == x1_q - COORD_W'(1));
  assign row_end = (row_q == y1_q - COORD_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_READ) begin
            state_d = S_RDATA;
          end else if (!fill_empty) begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: state_d = S_FILL;
      S_FILL: begin
        if (col_end && row_end) begin
          state_d = S_IDLE;
        end
      end
      S_RDATA: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_FILL:  mem_we     = 1'b1;
      S_RDATA: out_load   = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign fill_acc = in_acc && (command_i == CMD_FILL) && !fill_empty;
  assign read_acc = in_acc && (command_i == CMD_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_acc) begin
      x0_q    <= x_lo[COORD_W-1:0];
      x1_q    <= x_hi[COORD_W-1:0];
      y0_q    <= y_lo[COORD_W-1:0];
      y1_q    <= y_hi[COORD_W-1:0];
      color_q <= {fill_color_i[7:0], fill_color_i[15:8]};
    end
    if (state_q == S_SETUP) begin
      addr_q <= base_addr;
      step_q <= ADDR_W'(wid - span) + ADDR_W'(1);
      col_q  <= x0_q;
      row_q  <= y0_q;
    end else if (mem_we) begin
      if (col_end) begin
        col_q  <= x0_q;
        row_q  <= row_q + COORD_W'(1);
        addr_q <= addr_q + step_q;
      end else begin
        col_q  <= col_q + COORD_W'(1);
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      rd_data_q   <= mem_q[rd_addr];
      rd_inside_q <= rd_inside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q   <= rd_inside_q ? rd_data_q : '0;
      out_inside_q <= rd_inside_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_word_o = out_word_q;
  assign inside_res_o = out_inside_q;

endmodule

@@ rtl/core/cfb_checker.sv @@
// ---------------------------------------------------------------------------
// Clipped rectangle fill frame buffer checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "clipped_rect_fill_framebuffer_assert.svh"

module cfb_checker
  import cfb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             command_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] pixel_word_o,
  input logic             inside_res_o
);

  `CFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CFB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(pixel_word_o) && $stable(inside_res_o))
  `CFB_ASSERT_NOW(a_outside_zero, clk_i, rst_ni, out_valid_o && !inside_res_o, pixel_word_o == '0)
  `CFB_ASSERT_NEXT(a_read_latency, clk_i, rst_ni, in_valid_i && !in_stall_o && (command_i == CMD_READ) && !out_valid_o, !out_valid_o ##1 out_valid_o)

endmodule

bind clipped_rect_fill_framebuffer cfb_checker u_cfb_checker (.*);

@@ sim/tb_clipped_rect_fill_framebuffer.sv @@
// ---------------------------------------------------------------------------
// Testbench for the clipped rectangle fill frame buffer
// Drives fill and read transactions through bursty input gaps and patterned
// output stalls. A frame store copy predicts every read, and the rotation
// register is stepped through all of its settings between drained phases.
// ---------------------------------------------------------------------------
module tb_clipped_rect_fill_framebuffer;
  import cfb_pkg::*;

  typedef struct {
    logic                    command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] rect_w;
    logic signed [POS_W-1:0] rect_h;
    logic [PIX_W-1:0]        fill_color;
  } fb_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] pixel_word;
    logic             inside_res;
  } pixel_read_t;

  localparam logic [PADDR_W-1:0] ROT_ADDR = PADDR_W'(4 * CFG_IDX_ROTATION);
  localparam int AREA_BIG = 4096;

  class frame_scoreboard;
    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    logic [1:0]       rotation;
    pixel_read_t      pending_reads[$];
    int n_errors;
    int n_fills;
    int n_pixels;
    int n_reads;

    function new();
      rotation = 2'd0;
      n_errors = 0;
      n_fills  = 0;
      n_pixels = 0;
      n_reads  = 0;
    endfunction

    function int act_width();
      return rotation[0] ? SHORT_SIDE : LONG_SIDE;
    endfunction

    function int act_height();
      return rotation[0] ? LONG_SIDE : SHORT_SIDE;
    endfunction

    function bit clip_rect(fb_cmd_t c, output int x0, output int x1,
                           output int y0, output int y1);
      int px, py, rw, rh;
      px = c.pos_x;
      py = c.pos_y;
      rw = c.rect_w;
      rh = c.rect_h;
      x0 = 0;
      x1 = 0;
      y0 = 0;
      y1 = 0;
      if (rw <= 0 || rh <= 0) begin
        return 1'b0;
      end
      x0 = (px < 0) ? 0 : px;
      y0 = (py < 0) ? 0 : py;
      x1 = px + rw;
      y1 = py + rh;
      if (x1 > act_width()) begin
        x1 = act_width();
      end
      if (y1 > act_height()) begin
        y1 = act_height();
      end
      return (x1 > x0) && (y1 > y0);
    endfunction

    function int fill_area(fb_cmd_t c);
      int x0, x1, y0, y1;
      if (!clip_rect(c, x0, x1, y0, y1)) begin
        return 0;
      end
      return (x1 - x0) * (y1 - y0);
    endfunction

    function void note_command(fb_cmd_t c);
      int x0, x1, y0, y1, wid, px, py;
      pixel_read_t rd;
      wid = act_width();
      if (c.command == CMD_READ) begin
        px = c.pos_x;
        py = c.pos_y;
        rd.pixel_word = '0;
        rd.inside_res = 1'b0;
        if (px >= 0 && px < wid && py >= 0 && py < act_height()) begin
          rd.pixel_word = frame_mem[py * wid + px];
          rd.inside_res = 1'b1;
        end
        pending_reads.push_back(rd);
      end else begin
        n_fills++;
        if (clip_rect(c, x0, x1, y0, y1)) begin
          for (int row = y0; row < y1; row++) begin
            for (int col = x0; col < x1; col++) begin
              frame_mem[row * wid + col] = {c.fill_color[7:0], c.fill_color[15:8]};
            end
          end
          n_pixels += (x1 - x0) * (y1 - y0);
        end
      end
    endfunction

    task report_mismatch(string msg);
      if (n_errors < 100) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      n_errors++;
    endtask

    task check_read(logic [PIX_W-1:0] word, logic in_area);
      pixel_read_t exp_rd;
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("read result %h/%b with no read pending", word, in_area));
        return;
      end
      exp_rd = pending_reads.pop_front();
      n_reads++;
      if (word !== exp_rd.pixel_word) begin
        report_mismatch($sformatf("pixel_word %h, want %h", word, exp_rd.pixel_word));
      end
      if (in_area !== exp_rd.inside_res) begin
        report_mismatch($sformatf("inside_res %b, want %b", in_area, exp_rd.inside_res));
      end
    endtask
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [PDATA_W-1:0] pwdata       = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               command_i    = CMD_FILL;
  logic [POS_W-1:0]   pos_x_i      = '0;
  logic [POS_W-1:0]   pos_y_i      = '0;
  logic [POS_W-1:0]   rect_w_i     = '0;
  logic [POS_W-1:0]   rect_h_i     = '0;
  logic [PIX_W-1:0]   fill_color_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [PIX_W-1:0]   pixel_word_o;
  logic               inside_res_o;

  frame_scoreboard frame_model;
  int burst_left = 0;
  int big_left   = 5;
  int stall_tick = 0;
  int stall_mode = 0;
  int rot_seq[5] = '{1, 3, 2, 0, 1};

  clipped_rect_fill_framebuffer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .rect_w_i    (rect_w_i),
    .rect_h_i    (rect_h_i),
    .fill_color_i(fill_color_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_word_o(pixel_word_o),
    .inside_res_o(inside_res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 113 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= (stall_tick % 16) >= 10;
      end
      default: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frame_model.check_read(pixel_word_o, inside_res_o);
    end
  end

  function automatic fb_cmd_t mk_cmd(logic cmd, int x, int y, int w, int h, int color);
    fb_cmd_t c;
    c.command    = cmd;
    c.pos_x      = POS_W'(x);
    c.pos_y      = POS_W'(y);
    c.rect_w     = POS_W'(w);
    c.rect_h     = POS_W'(h);
    c.fill_color = PIX_W'(color);
    return c;
  endfunction

  task automatic send_cmd(fb_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= c.command;
    pos_x_i      <= c.pos_x;
    pos_y_i      <= c.pos_y;
    rect_w_i     <= c.rect_w;
    rect_h_i     <= c.rect_h;
    fill_color_i <= c.fill_color;
    do @(posedge clk_i); while (in_stall_o);
    frame_model.note_command(c);
    burst_left--;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (frame_model.pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_rotation(logic [1:0] rot);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROT_ADDR;
    pwdata  <= PDATA_W'(rot);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(rot)) begin
      frame_model.report_mismatch($sformatf("rotation reads back %h, want %h", prdata, rot));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    frame_model.rotation = rot;
  endtask

  task automatic run_phase(int n_items);
    fb_cmd_t c;
    int wid, hgt, kind, lx, ly, lw, lh;
    wid = frame_model.act_width();
    hgt = frame_model.act_height();
    lx = 0;
    ly = 0;
    lw = 1;
    lh = 1;
    repeat (n_items) begin
      do begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          lx = $urandom_range(0, wid + 15) - 8;
          ly = $urandom_range(0, hgt + 15) - 8;
          lw = $urandom_range(0, 18) - 2;
          lh = $urandom_range(0, 18) - 2;
          c = mk_cmd(CMD_FILL, lx, ly, lw, lh, $urandom);
        end else if (kind < 65) begin
          c = mk_cmd(CMD_READ, lx + $urandom_range(0, (lw > 0) ? lw + 1 : 1) - 1,
                     ly + $urandom_range(0, (lh > 0) ? lh + 1 : 1) - 1, 0, 0, 0);
        end else if (kind < 85) begin
          c = mk_cmd(CMD_READ, $urandom_range(0, wid + 3) - 2,
                     $urandom_range(0, hgt + 3) - 2, $urandom, $urandom, $urandom);
        end else if (kind < 88) begin
          c = mk_cmd(CMD_FILL, 0 - int'($urandom_range(0, 40)), 0 - int'($urandom_range(0, 40)),
                     $urandom_range(wid, 32767), $urandom_range(hgt, 32767), $urandom);
        end else begin
          c = mk_cmd($urandom_range(0, 1) ? CMD_READ : CMD_FILL,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      end while (c.command == CMD_FILL && frame_model.fill_area(c) > AREA_BIG && big_left == 0);
      if (c.command == CMD_FILL && frame_model.fill_area(c) > AREA_BIG) begin
        big_left--;
      end
      send_cmd(c);
    end
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
  endtask

  initial begin
    frame_model = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_rotation(2'd0);

    send_cmd(mk_cmd(CMD_FILL, -10, -7, 32767, 32767, 'h1234));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 319, 239, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 320, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 240, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, -1, 5, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, -32768, -32768, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 32767, 32767, 'hFFFF, 'hFFFF, 'hFFFF));
    send_cmd(mk_cmd(CMD_FILL, 5, 5, 0, 3, 'hFFFF));
    send_cmd(mk_cmd(CMD_FILL, 5, 5, -32768, 5, 'hFFFF));
    send_cmd(mk_cmd(CMD_FILL, 5, 5, 4, -1, 'hFFFF));
    send_cmd(mk_cmd(CMD_READ, 5, 5, 0, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 400, 0, 10, 10, 'hFFFF));
    send_cmd(mk_cmd(CMD_FILL, -20, 0, 20, 5, 'hFFFF));
    send_cmd(mk_cmd(CMD_FILL, 32767, 32767, 32767, 32767, 'hFFFF));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 315, 236, 10, 10, 'h00FF));
    send_cmd(mk_cmd(CMD_READ, 319, 239, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 314, 239, 0, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 100, 50, 1, 1, 'hABCD));
    send_cmd(mk_cmd(CMD_READ, 100, 50, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 101, 50, 0, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, -3, -2, 5, 4, 'h8001));
    send_cmd(mk_cmd(CMD_READ, 1, 1, 0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 2, 1, 0, 0, 0));
    settle();

    foreach (rot_seq[i]) begin
      set_rotation(rot_seq[i][1:0]);
      run_phase(80);
      settle();
    end

    $display("covered %0d fills writing %0d pixels and %0d checked reads",
             frame_model.n_fills, frame_model.n_pixels, frame_model.n_reads);
    $display("across all four rotation settings with input gaps and output stalls");
    if (frame_model.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
